[rtl/bmr_pkg.sv]
package bmr_pkg;

	// Largest mask the stores are sized for.
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;

	// Coordinate, raster index and pixel count widths.
	localparam int XW     = $clog2(MAX_WIDTH);
	localparam int YW     = $clog2(MAX_HEIGHT);
	localparam int AW     = XW + YW;
	localparam int NPIX_W = AW + 1;
	localparam int SZA_W  = AW - 1;

	// Widths fixed by the register and result fields.
	localparam int DIM_W  = 9;
	localparam int CNT_W  = 17;
	localparam int CMP_W  = 16;
	localparam int PASS_W = 4;
	localparam int CFG_AW = 3;

	// A smoothed pixel is set when at least this many of its nine pixels are set.
	localparam logic [3:0] MAJ_MIN = 4'd5;

	// Operation codes of an input transaction.
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_RUN   = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Configuration register indexes.
	localparam logic [CFG_AW-1:0] CFG_WIDTH     = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_HEIGHT    = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_LARGEST   = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_MIN_SIZE  = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_FILL_EN   = 3'd4;
	localparam logic [CFG_AW-1:0] CFG_SMOOTH_EN = 3'd5;
	localparam logic [CFG_AW-1:0] CFG_PASSES    = 3'd6;

	// Effective configuration as seen by the sequencer.
	typedef struct packed {
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
		logic [NPIX_W-1:0] n;
		logic              keep_largest;
		logic [CNT_W-1:0]  min_size;
		logic              fill_en;
		logic              smooth_en;
		logic [PASS_W-1:0] passes;
	} cfg_t;

	// One accepted input transaction.
	typedef struct packed {
		logic          start;
		logic [1:0]    op;
		logic [AW-1:0] idx;
		logic          pix;
	} req_t;

	// Sequencer handshake status.
	typedef struct packed {
		logic idle;
		logic res_valid;
	} ctl_t;

	// One result transaction.
	typedef struct packed {
		logic              status;
		logic              pix;
		logic [CNT_W-1:0]  fg_before;
		logic [CNT_W-1:0]  fg_after;
		logic [CMP_W-1:0]  comps_before;
		logic [CMP_W-1:0]  comps_after;
		logic [CMP_W-1:0]  comps_removed;
		logic [CNT_W-1:0]  holes_filled;
		logic [PASS_W-1:0] passes_done;
	} res_t;

endpackage

[rtl/bmr_ram.sv]
module bmr_ram #(
	parameter int AW = 16,
	parameter int DW = 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/bmr_seq.sv]
module bmr_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  bmr_pkg::cfg_t cfg,
	input  bmr_pkg::req_t req,
	input  logic          ack,
	output bmr_pkg::ctl_t ctl,
	output bmr_pkg::res_t res
);

	typedef enum logic [20:0] {
		S_IDLE  = 21'd1 << 0,
		S_RD    = 21'd1 << 1,
		S_DONE  = 21'd1 << 2,
		S_SW_R  = 21'd1 << 3,
		S_SW_W2 = 21'd1 << 4,
		S_SW_U  = 21'd1 << 5,
		S_SC_A  = 21'd1 << 6,
		S_SC_R  = 21'd1 << 7,
		S_SC_U  = 21'd1 << 8,
		S_POP   = 21'd1 << 9,
		S_POP_W = 21'd1 << 10,
		S_NB    = 21'd1 << 11,
		S_NB_R  = 21'd1 << 12,
		S_NB_U  = 21'd1 << 13,
		S_SZ_R  = 21'd1 << 14,
		S_SZ_U  = 21'd1 << 15,
		S_SM_A  = 21'd1 << 16,
		S_SM_R  = 21'd1 << 17,
		S_SM_U  = 21'd1 << 18,
		S_NEXT  = 21'd1 << 19,
		S_SPARE = 21'd1 << 20
	} state_t;

	typedef enum logic [11:0] {
		PH_CNT0  = 12'd1 << 0,
		PH_LAB0  = 12'd1 << 1,
		PH_SIZES = 12'd1 << 2,
		PH_FILT  = 12'd1 << 3,
		PH_FCLR  = 12'd1 << 4,
		PH_FILL  = 12'd1 << 5,
		PH_FSCAN = 12'd1 << 6,
		PH_SPASS = 12'd1 << 7,
		PH_SCOPY = 12'd1 << 8,
		PH_LCLR  = 12'd1 << 9,
		PH_LAB1  = 12'd1 << 10,
		PH_CNT1  = 12'd1 << 11
	} phase_t;

	localparam int MW = bmr_pkg::YW + bmr_pkg::DIM_W;

	state_t state_q;
	phase_t phase_q, nxt_ph, post_filt, post_fill;

	logic [bmr_pkg::AW-1:0]     i_q, addr_q, caddr_q, addr_nxt;
	logic [bmr_pkg::XW-1:0]     sx_q, px_q, nx_q, ax, nbx;
	logic [bmr_pkg::YW-1:0]     sy_q, py_q, ny_q, ay, nby;
	logic [1:0]                 k_q, kx_q, ky_q, ekx, eky;
	logic [3:0]                 csum_q, csum_nxt;
	logic [bmr_pkg::NPIX_W-1:0] head_q, tail_q;
	logic [bmr_pkg::CNT_W-1:0]  size_q, lsize_q, fg_q, filled_q;
	logic [bmr_pkg::CMP_W-1:0]  count_q, c_q, largest_q, below_q, lidx;
	logic [bmr_pkg::PASS_W-1:0] pass_q;
	logic [MW-1:0]              mul;
	bmr_pkg::res_t              res_q;

	logic is_lab, border, ras_last, nb_ok, seed_ok, nb_cond, idx_ok, keep, smooth_go;
	logic pix_done, below_min;

	// Memory ports.
	logic                       m_we, m_wd, m_re, m_rd;
	logic [bmr_pkg::AW-1:0]     m_wa, m_ra;
	logic                       s_we, s_wd, s_re, s_rd;
	logic [bmr_pkg::AW-1:0]     s_wa, s_ra;
	logic                       l_we, l_re;
	logic [bmr_pkg::AW-1:0]     l_wa, l_ra;
	logic [bmr_pkg::CMP_W-1:0]  l_wd, l_rd;
	logic                       q_we, q_re;
	logic [bmr_pkg::AW-1:0]     q_wa, q_ra, q_wd, q_rd;
	logic                       z_we, z_re;
	logic [bmr_pkg::SZA_W-1:0]  z_wa, z_ra;
	logic [bmr_pkg::CNT_W-1:0]  z_wd, z_rd;

	bmr_ram #(.AW(bmr_pkg::AW), .DW(1)) u_mask (
		.clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd),
		.re(m_re), .raddr(m_ra), .rdata(m_rd)
	);
	bmr_ram #(.AW(bmr_pkg::AW), .DW(1)) u_scratch (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd),
		.re(s_re), .raddr(s_ra), .rdata(s_rd)
	);
	bmr_ram #(.AW(bmr_pkg::AW), .DW(bmr_pkg::CMP_W)) u_label (
		.clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd),
		.re(l_re), .raddr(l_ra), .rdata(l_rd)
	);
	bmr_ram #(.AW(bmr_pkg::AW), .DW(bmr_pkg::AW)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd),
		.re(q_re), .raddr(q_ra), .rdata(q_rd)
	);
	bmr_ram #(.AW(bmr_pkg::SZA_W), .DW(bmr_pkg::CNT_W)) u_sizes (
		.clk(clk), .we(z_we), .waddr(z_wa), .wdata(z_wd),
		.re(z_re), .raddr(z_ra), .rdata(z_rd)
	);

	// Position tests on the current raster pixel.
	assign is_lab   = (phase_q == PH_LAB0) || (phase_q == PH_LAB1);
	assign ras_last = (bmr_pkg::DIM_W'(sx_q) == cfg.w - 1'b1) &&
	                  (bmr_pkg::DIM_W'(sy_q) == cfg.h - 1'b1);
	assign border   = (sx_q == '0) || (sy_q == '0) ||
	                  (bmr_pkg::DIM_W'(sx_q) == cfg.w - 1'b1) ||
	                  (bmr_pkg::DIM_W'(sy_q) == cfg.h - 1'b1);
	assign idx_ok   = bmr_pkg::NPIX_W'(req.idx) < cfg.n;

	// Seed and flood conditions: foreground without a label, or unmarked background.
	assign seed_ok = is_lab ? (m_rd && (l_rd == '0)) : (border && !m_rd && !s_rd);
	assign nb_cond = is_lab ? (m_rd && (l_rd == '0)) : (!m_rd && !s_rd);

	// Filter decision for the label just read.
	assign lidx      = l_rd - 1'b1;
	assign keep      = cfg.keep_largest ? (lidx == largest_q) : (z_rd >= cfg.min_size);
	assign below_min = z_rd < cfg.min_size;

	// Majority window walk: border pixels only visit their center.
	assign ekx      = border ? 2'd1 : kx_q;
	assign eky      = border ? 2'd1 : ky_q;
	assign csum_nxt = csum_q + 4'(m_rd);
	assign pix_done = border || ((kx_q == 2'd2) && (ky_q == 2'd2));

	assign smooth_go = cfg.smooth_en && (cfg.passes != '0) &&
	                   (cfg.w >= bmr_pkg::DIM_W'(3)) && (cfg.h >= bmr_pkg::DIM_W'(3));

	// Neighbor k of the popped pixel: right, left, down, up.
	always_comb begin
		nbx   = px_q;
		nby   = py_q;
		nb_ok = 1'b0;
		unique case (k_q)
			2'd0: begin
				nb_ok = (bmr_pkg::DIM_W'(px_q) + 1'b1) < cfg.w;
				nbx   = px_q + 1'b1;
			end
			2'd1: begin
				nb_ok = px_q != '0;
				nbx   = px_q - 1'b1;
			end
			2'd2: begin
				nb_ok = (bmr_pkg::DIM_W'(py_q) + 1'b1) < cfg.h;
				nby   = py_q + 1'b1;
			end
			default: begin
				nb_ok = py_q != '0;
				nby   = py_q - 1'b1;
			end
		endcase
	end

	// Shared address unit: raster index y * width + x.
	always_comb begin
		ax = sx_q;
		ay = sy_q;
		if (state_q == S_NB) begin
			ax = nbx;
			ay = nby;
		end else if (state_q == S_SM_A) begin
			ax = sx_q + bmr_pkg::XW'(ekx) - 1'b1;
			ay = sy_q + bmr_pkg::YW'(eky) - 1'b1;
		end
	end
	assign mul      = MW'(ay) * MW'(cfg.w);
	assign addr_nxt = bmr_pkg::AW'(mul + MW'(ax));

	// Phase order of a run.
	always_comb begin
		post_fill = smooth_go ? PH_SPASS : PH_LCLR;
		post_filt = cfg.fill_en ? PH_FCLR : post_fill;
		unique case (phase_q)
			PH_CNT0:  nxt_ph = PH_LAB0;
			PH_LAB0:  nxt_ph = (count_q == '0) ? post_filt : PH_SIZES;
			PH_SIZES: nxt_ph = PH_FILT;
			PH_FILT:  nxt_ph = post_filt;
			PH_FCLR:  nxt_ph = PH_FILL;
			PH_FILL:  nxt_ph = PH_FSCAN;
			PH_FSCAN: nxt_ph = post_fill;
			PH_SPASS: nxt_ph = PH_SCOPY;
			PH_SCOPY: nxt_ph = ((5'(pass_q) + 1'b1) < 5'(cfg.passes)) ? PH_SPASS : PH_LCLR;
			PH_LCLR:  nxt_ph = PH_LAB1;
			PH_LAB1:  nxt_ph = PH_CNT1;
			default:  nxt_ph = PH_CNT1;
		endcase
	end

	// Memory read and write controls.
	always_comb begin
		m_we = 1'b0; m_wa = i_q;    m_wd = 1'b0;
		m_re = 1'b0; m_ra = addr_q;
		s_we = 1'b0; s_wa = addr_q; s_wd = 1'b1;
		s_re = 1'b0; s_ra = addr_q;
		l_we = 1'b0; l_wa = addr_q; l_wd = count_q;
		l_re = 1'b0; l_ra = addr_q;
		q_we = 1'b0; q_wa = tail_q[bmr_pkg::AW-1:0]; q_wd = {ny_q, nx_q};
		q_re = 1'b0; q_ra = head_q[bmr_pkg::AW-1:0];
		z_we = 1'b0; z_wa = bmr_pkg::SZA_W'(count_q - 1'b1); z_wd = size_q;
		z_re = 1'b0; z_ra = bmr_pkg::SZA_W'(lidx);
		unique case (state_q)
			S_IDLE: begin
				m_ra = req.idx;
				m_wa = req.idx;
				m_wd = req.pix;
				m_we = req.start && idx_ok && (req.op == bmr_pkg::OP_WRITE);
				m_re = req.start && idx_ok && (req.op == bmr_pkg::OP_READ);
			end
			S_SW_R: begin
				m_re = 1'b1; m_ra = i_q;
				s_re = 1'b1; s_ra = i_q;
				l_re = 1'b1; l_ra = i_q;
				l_wa = i_q;  l_wd = '0;
				l_we = (phase_q == PH_CNT0) || (phase_q == PH_LCLR);
				s_wa = i_q;  s_wd = 1'b0;
				s_we = phase_q == PH_FCLR;
			end
			S_SW_W2: z_re = l_rd != '0;
			S_SW_U: begin
				if (phase_q == PH_FILT) begin
					m_we = (l_rd != '0) && !keep;
					m_wd = 1'b0;
				end else if (phase_q == PH_FSCAN) begin
					m_we = !m_rd && !s_rd;
					m_wd = 1'b1;
				end else if (phase_q == PH_SCOPY) begin
					m_we = 1'b1;
					m_wd = s_rd;
				end
			end
			S_SC_R, S_NB_R: begin
				m_re = 1'b1;
				s_re = 1'b1;
				l_re = 1'b1;
			end
			S_SC_U: begin
				l_we = seed_ok && is_lab;
				l_wd = count_q + 1'b1;
				s_we = seed_ok && !is_lab;
				q_we = seed_ok;
				q_wa = '0;
				q_wd = {sy_q, sx_q};
			end
			S_POP: begin
				q_re = head_q != tail_q;
				z_we = (head_q == tail_q) && is_lab;
			end
			S_NB_U: begin
				l_we = nb_cond && is_lab;
				s_we = nb_cond && !is_lab;
				q_we = nb_cond;
			end
			S_SZ_R: begin
				z_re = 1'b1;
				z_ra = bmr_pkg::SZA_W'(c_q);
			end
			S_SM_R: m_re = 1'b1;
			S_SM_U: begin
				s_we = pix_done;
				s_wa = border ? addr_q : caddr_q;
				s_wd = border ? m_rd : (csum_nxt >= bmr_pkg::MAJ_MIN);
			end
			default: begin
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_CNT0;
			res_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.start) begin
						res_q.pix <= 1'b0;
						unique case (req.op)
							bmr_pkg::OP_WRITE: begin
								res_q.status <= !idx_ok;
								state_q      <= S_DONE;
							end
							bmr_pkg::OP_READ: begin
								res_q.status <= !idx_ok;
								state_q      <= idx_ok ? S_RD : S_DONE;
							end
							bmr_pkg::OP_RUN: begin
								res_q.status        <= 1'b0;
								phase_q             <= PH_CNT0;
								i_q                 <= '0;
								fg_q                <= '0;
								pass_q              <= '0;
								res_q.comps_removed <= '0;
								res_q.holes_filled  <= '0;
								res_q.passes_done   <= cfg.smooth_en ? cfg.passes : '0;
								state_q             <= S_SW_R;
							end
							default: begin
								res_q.status <= 1'b0;
								state_q      <= S_DONE;
							end
						endcase
					end
				end
				S_RD: begin
					res_q.pix <= m_rd;
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (ack) begin
						state_q <= S_IDLE;
					end
				end
				S_SW_R: state_q <= (phase_q == PH_FILT) ? S_SW_W2 : S_SW_U;
				S_SW_W2: state_q <= S_SW_U;
				S_SW_U: begin
					if ((phase_q == PH_CNT0) || (phase_q == PH_CNT1)) begin
						fg_q <= fg_q + bmr_pkg::CNT_W'(m_rd);
					end
					if ((phase_q == PH_FSCAN) && !m_rd && !s_rd) begin
						filled_q <= filled_q + 1'b1;
					end
					if ((bmr_pkg::NPIX_W'(i_q) + 1'b1) == cfg.n) begin
						state_q <= S_NEXT;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_SW_R;
					end
				end
				S_SC_A: begin
					addr_q  <= addr_nxt;
					state_q <= S_SC_R;
				end
				S_SC_R: state_q <= S_SC_U;
				S_SC_U: begin
					if (seed_ok) begin
						if (is_lab) begin
							count_q <= count_q + 1'b1;
						end
						head_q  <= '0;
						tail_q  <= bmr_pkg::NPIX_W'(1);
						size_q  <= '0;
						state_q <= S_POP;
					end else if (ras_last) begin
						state_q <= S_NEXT;
					end else begin
						if (bmr_pkg::DIM_W'(sx_q) == cfg.w - 1'b1) begin
							sx_q <= '0;
							sy_q <= sy_q + 1'b1;
						end else begin
							sx_q <= sx_q + 1'b1;
						end
						state_q <= S_SC_A;
					end
				end
				S_POP: begin
					if (head_q == tail_q) begin
						if (ras_last) begin
							state_q <= S_NEXT;
						end else begin
							if (bmr_pkg::DIM_W'(sx_q) == cfg.w - 1'b1) begin
								sx_q <= '0;
								sy_q <= sy_q + 1'b1;
							end else begin
								sx_q <= sx_q + 1'b1;
							end
							state_q <= S_SC_A;
						end
					end else begin
						head_q  <= head_q + 1'b1;
						state_q <= S_POP_W;
					end
				end
				S_POP_W: begin
					px_q    <= q_rd[bmr_pkg::XW-1:0];
					py_q    <= q_rd[bmr_pkg::AW-1:bmr_pkg::XW];
					size_q  <= size_q + 1'b1;
					k_q     <= '0;
					state_q <= S_NB;
				end
				S_NB: begin
					if (nb_ok) begin
						addr_q  <= addr_nxt;
						nx_q    <= nbx;
						ny_q    <= nby;
						state_q <= S_NB_R;
					end else if (k_q == 2'd3) begin
						state_q <= S_POP;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_NB_R: state_q <= S_NB_U;
				S_NB_U: begin
					if (nb_cond) begin
						tail_q <= tail_q + 1'b1;
					end
					if (k_q == 2'd3) begin
						state_q <= S_POP;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_NB;
					end
				end
				S_SZ_R: state_q <= S_SZ_U;
				S_SZ_U: begin
					if ((c_q == '0) || (z_rd > lsize_q)) begin
						largest_q <= c_q;
						lsize_q   <= z_rd;
					end
					if (below_min) begin
						below_q <= below_q + 1'b1;
					end
					if ((c_q + 1'b1) == count_q) begin
						res_q.comps_removed <= cfg.keep_largest ? (count_q - 1'b1) :
						                       (below_q + bmr_pkg::CMP_W'(below_min));
						state_q <= S_NEXT;
					end else begin
						c_q     <= c_q + 1'b1;
						state_q <= S_SZ_R;
					end
				end
				S_SM_A: begin
					addr_q  <= addr_nxt;
					state_q <= S_SM_R;
				end
				S_SM_R: state_q <= S_SM_U;
				S_SM_U: begin
					if ((kx_q == 2'd1) && (ky_q == 2'd1)) begin
						caddr_q <= addr_q;
					end
					if (pix_done) begin
						csum_q <= '0;
						kx_q   <= '0;
						ky_q   <= '0;
						if (ras_last) begin
							state_q <= S_NEXT;
						end else begin
							if (bmr_pkg::DIM_W'(sx_q) == cfg.w - 1'b1) begin
								sx_q <= '0;
								sy_q <= sy_q + 1'b1;
							end else begin
								sx_q <= sx_q + 1'b1;
							end
							state_q <= S_SM_A;
						end
					end else begin
						csum_q <= csum_nxt;
						if (kx_q == 2'd2) begin
							kx_q <= '0;
							ky_q <= ky_q + 1'b1;
						end else begin
							kx_q <= kx_q + 1'b1;
						end
						state_q <= S_SM_A;
					end
				end
				S_NEXT: begin
					// Record what the finished phase produced.
					unique case (phase_q)
						PH_CNT0:  res_q.fg_before    <= fg_q;
						PH_LAB0:  res_q.comps_before <= count_q;
						PH_FSCAN: res_q.holes_filled <= filled_q;
						PH_SCOPY: pass_q             <= pass_q + 1'b1;
						PH_LAB1:  res_q.comps_after  <= count_q;
						PH_CNT1:  res_q.fg_after     <= fg_q;
						default: begin
						end
					endcase
					phase_q <= nxt_ph;
					// Set up the next phase.
					if (phase_q == PH_CNT1) begin
						state_q <= S_DONE;
					end else begin
						unique case (nxt_ph)
							PH_LAB0, PH_LAB1, PH_FILL: begin
								sx_q    <= '0;
								sy_q    <= '0;
								count_q <= '0;
								state_q <= S_SC_A;
							end
							PH_SIZES: begin
								c_q     <= '0;
								below_q <= '0;
								state_q <= S_SZ_R;
							end
							PH_SPASS: begin
								sx_q    <= '0;
								sy_q    <= '0;
								kx_q    <= '0;
								ky_q    <= '0;
								csum_q  <= '0;
								state_q <= S_SM_A;
							end
							default: begin
								i_q      <= '0;
								fg_q     <= '0;
								filled_q <= '0;
								state_q  <= S_SW_R;
							end
						endcase
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign ctl.idle      = state_q == S_IDLE;
	assign ctl.res_valid = state_q == S_DONE;
	assign res           = res_q;

endmodule

[rtl/binary_mask_refiner.sv]
// Binary mask refiner. Load a mask with write transactions (op 0), start a run with op 1,
// and read refined pixels back with op 2; every transaction returns one result that carries
// the report counts of the latest run. A run walks the mask through memories with one write
// and one read port each and one shared y*width+x address unit, so its length grows with
// the pixel count n. It is made of counting, clearing and copy sweeps, a component filter
// sweep, floods (labeling twice, hole filling once) and smoothing passes. No clearing pass
// follows reset: every working store is cleared inside the run that uses it, and the mask
// must be written before it is read.
module binary_mask_refiner (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    op,
	input  logic [bmr_pkg::AW-1:0]        pixel_index,
	input  logic                          pixel_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          status,
	output logic                          pixel_out,
	output logic [bmr_pkg::CNT_W-1:0]     fg_before,
	output logic [bmr_pkg::CNT_W-1:0]     fg_after,
	output logic [bmr_pkg::CMP_W-1:0]     comps_before,
	output logic [bmr_pkg::CMP_W-1:0]     comps_after,
	output logic [bmr_pkg::CMP_W-1:0]     comps_removed,
	output logic [bmr_pkg::CNT_W-1:0]     holes_filled,
	output logic [bmr_pkg::PASS_W-1:0]    passes_done,
	input  logic                          cfg_we,
	input  logic [bmr_pkg::CFG_AW-1:0]    cfg_index,
	input  logic [bmr_pkg::CNT_W-1:0]     cfg_wdata
);

	logic [bmr_pkg::DIM_W-1:0]   width_q, height_q, eff_w, eff_h;
	logic [2*bmr_pkg::DIM_W-1:0] area;
	logic                        largest_q, fill_q, smooth_q;
	logic [bmr_pkg::CNT_W-1:0]   min_size_q;
	logic [bmr_pkg::PASS_W-1:0]  passes_q;
	logic                        out_valid_q, ack;
	bmr_pkg::cfg_t               cfg;
	bmr_pkg::req_t               req;
	bmr_pkg::ctl_t               ctl;
	bmr_pkg::res_t               res, out_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= bmr_pkg::DIM_W'(256);
			height_q   <= bmr_pkg::DIM_W'(256);
			largest_q  <= 1'b1;
			min_size_q <= '0;
			fill_q     <= 1'b1;
			smooth_q   <= 1'b0;
			passes_q   <= bmr_pkg::PASS_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				bmr_pkg::CFG_WIDTH:     width_q    <= cfg_wdata[bmr_pkg::DIM_W-1:0];
				bmr_pkg::CFG_HEIGHT:    height_q   <= cfg_wdata[bmr_pkg::DIM_W-1:0];
				bmr_pkg::CFG_LARGEST:   largest_q  <= cfg_wdata[0];
				bmr_pkg::CFG_MIN_SIZE:  min_size_q <= cfg_wdata;
				bmr_pkg::CFG_FILL_EN:   fill_q     <= cfg_wdata[0];
				bmr_pkg::CFG_SMOOTH_EN: smooth_q   <= cfg_wdata[0];
				bmr_pkg::CFG_PASSES:    passes_q   <= cfg_wdata[bmr_pkg::PASS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Mask size saturated to the supported range.
	always_comb begin
		eff_w = width_q;
		eff_h = height_q;
		if (width_q == '0) begin
			eff_w = bmr_pkg::DIM_W'(1);
		end else if (width_q > bmr_pkg::DIM_W'(bmr_pkg::MAX_WIDTH)) begin
			eff_w = bmr_pkg::DIM_W'(bmr_pkg::MAX_WIDTH);
		end
		if (height_q == '0) begin
			eff_h = bmr_pkg::DIM_W'(1);
		end else if (height_q > bmr_pkg::DIM_W'(bmr_pkg::MAX_HEIGHT)) begin
			eff_h = bmr_pkg::DIM_W'(bmr_pkg::MAX_HEIGHT);
		end
	end
	assign area = (2*bmr_pkg::DIM_W)'(eff_w) * (2*bmr_pkg::DIM_W)'(eff_h);

	assign cfg.w            = eff_w;
	assign cfg.h            = eff_h;
	assign cfg.n            = area[bmr_pkg::NPIX_W-1:0];
	assign cfg.keep_largest = largest_q;
	assign cfg.min_size     = min_size_q;
	assign cfg.fill_en      = fill_q;
	assign cfg.smooth_en    = smooth_q;
	assign cfg.passes       = passes_q;

	// Input transaction into the sequencer.
	assign in_ready  = ctl.idle;
	assign req.start = in_valid && ctl.idle;
	assign req.op    = op;
	assign req.idx   = pixel_index;
	assign req.pix   = pixel_in;

	bmr_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.req(req),
		.ack(ack),
		.ctl(ctl),
		.res(res)
	);

	// Output register: a finished result moves here once the previous one is taken.
	assign ack = ctl.res_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign pixel_out     = out_q.pix;
	assign fg_before     = out_q.fg_before;
	assign fg_after      = out_q.fg_after;
	assign comps_before  = out_q.comps_before;
	assign comps_after   = out_q.comps_after;
	assign comps_removed = out_q.comps_removed;
	assign holes_filled  = out_q.holes_filled;
	assign passes_done   = out_q.passes_done;

	// An accepted transaction leaves the sequencer busy in the cycle after it is accepted.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sequencer idle right after accepting a transaction");

	// A refined pixel is only returned for an index inside the mask.
	a_pix_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pixel_out |-> !status)
		else $error("pixel returned together with out of range status");

	// A run never removes more components than it found.
	a_removed_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> comps_removed <= comps_before)
		else $error("removed component count exceeds component count");

	// A result transaction stays offered until the consumer takes it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result transaction dropped before it was taken");

endmodule

[verif/tb_binary_mask_refiner.sv]
module tb_binary_mask_refiner;

	localparam int NPIX        = bmr_pkg::MAX_WIDTH * bmr_pkg::MAX_HEIGHT;
	localparam int IDLE_LIMIT  = 2000000;
	localparam int ITEM_TARGET = 1800;

	typedef struct {
		bmr_pkg::op_t           op;
		logic [bmr_pkg::AW-1:0] idx;
		logic                   pix;
	} mask_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] op = '0;
	logic [bmr_pkg::AW-1:0] pixel_index = '0;
	logic pixel_in = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic status;
	logic pixel_out;
	logic [bmr_pkg::CNT_W-1:0] fg_before;
	logic [bmr_pkg::CNT_W-1:0] fg_after;
	logic [bmr_pkg::CMP_W-1:0] comps_before;
	logic [bmr_pkg::CMP_W-1:0] comps_after;
	logic [bmr_pkg::CMP_W-1:0] comps_removed;
	logic [bmr_pkg::CNT_W-1:0] holes_filled;
	logic [bmr_pkg::PASS_W-1:0] passes_done;
	logic cfg_we = 1'b0;
	logic [bmr_pkg::CFG_AW-1:0] cfg_index = '0;
	logic [bmr_pkg::CNT_W-1:0] cfg_wdata = '0;

	mask_cmd_t       pending_cmds[$];
	bmr_pkg::res_t   expected_results[$];
	int        errors = 0;
	int        idle_cycles = 0;
	int        in_gap = 0;
	int        out_stall = 0;
	bit        calm = 1'b0;

	// Shadow of the refiner state used to predict every result.
	bit mk[NPIX];
	bit scr[NPIX];
	int lab[NPIX];
	int csz[NPIX];
	int pq[NPIX];
	int rc[7];
	int cw, ch, ckeep, cmin, cfill, csmooth, cpass;

	// Written flags seen by the stimulus generator.
	bit gen_written[NPIX];
	int gen_count = 0;

	binary_mask_refiner DUT (.*);

	always #10 clk = ~clk;

	function automatic int eff_w();
		return (cw < 1) ? 1 : ((cw > bmr_pkg::MAX_WIDTH) ? bmr_pkg::MAX_WIDTH : cw);
	endfunction

	function automatic int eff_h();
		return (ch < 1) ? 1 : ((ch > bmr_pkg::MAX_HEIGHT) ? bmr_pkg::MAX_HEIGHT : ch);
	endfunction

	function automatic int count_fg(int n);
		int c;
		c = 0;
		for (int i = 0; i < n; i++) c += mk[i];
		return c;
	endfunction

	// Flood labeling of 4-connected foreground in raster order of first pixel.
	function automatic int label_all(int w, int h);
		int count, head, tail, sz, p, x, y;
		count = 0;
		for (int i = 0; i < w * h; i++) lab[i] = 0;
		for (int s = 0; s < w * h; s++) begin
			if (!mk[s] || lab[s] != 0) continue;
			count++;
			lab[s] = count;
			head = 0;
			tail = 0;
			sz = 0;
			pq[tail++] = s;
			while (head < tail) begin
				p = pq[head++];
				x = p % w;
				y = p / w;
				sz++;
				if (x + 1 < w && mk[p+1] && lab[p+1] == 0) begin lab[p+1] = count; pq[tail++] = p + 1; end
				if (x > 0 && mk[p-1] && lab[p-1] == 0) begin lab[p-1] = count; pq[tail++] = p - 1; end
				if (y + 1 < h && mk[p+w] && lab[p+w] == 0) begin lab[p+w] = count; pq[tail++] = p + w; end
				if (y > 0 && mk[p-w] && lab[p-w] == 0) begin lab[p-w] = count; pq[tail++] = p - w; end
			end
			csz[count-1] = sz;
		end
		return count;
	endfunction

	// Drops components by the largest rule or the minimum size rule.
	function automatic int filter_comps(int w, int h);
		int count, largest, removed;
		bit keep;
		count = label_all(w, h);
		largest = 0;
		removed = 0;
		if (count == 0) return 0;
		for (int i = 1; i < count; i++) if (csz[i] > csz[largest]) largest = i;
		for (int i = 0; i < NPIX; i++) scr[i] = 0;
		for (int i = 0; i < count; i++) begin
			keep = ckeep ? (i == largest) : (csz[i] >= cmin);
			scr[i] = keep;
			if (!keep) removed++;
		end
		for (int i = 0; i < w * h; i++) if (lab[i] != 0 && !scr[lab[i]-1]) mk[i] = 0;
		return removed;
	endfunction

	function automatic void seed_out(int p, ref int tail);
		if (mk[p] || scr[p]) return;
		scr[p] = 1;
		pq[tail++] = p;
	endfunction

	// Background not reachable from the border becomes foreground.
	function automatic int fill_holes(int w, int h);
		int head, tail, filled, p, x, y;
		head = 0;
		tail = 0;
		filled = 0;
		for (int i = 0; i < NPIX; i++) scr[i] = 0;
		for (int i = 0; i < w; i++) begin seed_out(i, tail); seed_out((h - 1) * w + i, tail); end
		for (int i = 0; i < h; i++) begin seed_out(i * w, tail); seed_out(i * w + w - 1, tail); end
		while (head < tail) begin
			p = pq[head++];
			x = p % w;
			y = p / w;
			if (x + 1 < w) seed_out(p + 1, tail);
			if (x > 0) seed_out(p - 1, tail);
			if (y + 1 < h) seed_out(p + w, tail);
			if (y > 0) seed_out(p - w, tail);
		end
		for (int i = 0; i < w * h; i++) if (!mk[i] && !scr[i]) begin mk[i] = 1; filled++; end
		return filled;
	endfunction

	// Majority passes over interior pixels; the border is left alone.
	function automatic void smooth_mask(int w, int h, int passes);
		int c;
		if (w < 3 || h < 3) return;
		for (int it = 0; it < passes; it++) begin
			for (int i = 0; i < w * h; i++) scr[i] = mk[i];
			for (int y = 1; y + 1 < h; y++)
				for (int x = 1; x + 1 < w; x++) begin
					c = 0;
					for (int yy = y - 1; yy <= y + 1; yy++)
						for (int xx = x - 1; xx <= x + 1; xx++) c += mk[yy * w + xx];
					scr[y * w + x] = (c >= int'(bmr_pkg::MAJ_MIN));
				end
			for (int i = 0; i < w * h; i++) mk[i] = scr[i];
		end
	endfunction

	function automatic void refine_mask();
		int w, h;
		w = eff_w();
		h = eff_h();
		rc[0] = count_fg(w * h);
		rc[2] = label_all(w, h);
		rc[4] = filter_comps(w, h);
		rc[5] = cfill ? fill_holes(w, h) : 0;
		rc[6] = 0;
		if (csmooth) begin
			smooth_mask(w, h, cpass);
			rc[6] = cpass;
		end
		rc[3] = label_all(w, h);
		rc[1] = count_fg(w * h);
	endfunction

	function automatic bmr_pkg::res_t predict_result(mask_cmd_t c);
		bmr_pkg::res_t r;
		int n;
		n = eff_w() * eff_h();
		r = '0;
		if (c.op == bmr_pkg::OP_WRITE || c.op == bmr_pkg::OP_READ) begin
			if (int'(c.idx) >= n) r.status = 1'b1;
			else if (c.op == bmr_pkg::OP_WRITE) mk[c.idx] = c.pix;
			else r.pix = mk[c.idx];
		end else if (c.op == bmr_pkg::OP_RUN) begin
			refine_mask();
		end
		r.fg_before     = rc[0][bmr_pkg::CNT_W-1:0];
		r.fg_after      = rc[1][bmr_pkg::CNT_W-1:0];
		r.comps_before  = rc[2][bmr_pkg::CMP_W-1:0];
		r.comps_after   = rc[3][bmr_pkg::CMP_W-1:0];
		r.comps_removed = rc[4][bmr_pkg::CMP_W-1:0];
		r.holes_filled  = rc[5][bmr_pkg::CNT_W-1:0];
		r.passes_done   = rc[6][bmr_pkg::PASS_W-1:0];
		return r;
	endfunction

	function automatic void check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// Driver: presents queued transactions and predicts each one at acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				mask_cmd_t c;
				c.op = bmr_pkg::op_t'(op);
				c.idx = pixel_index;
				c.pix = pixel_in;
				expected_results.insert(expected_results.size(), predict_result(c));
				in_gap = calm ? 0 : $urandom_range(0, 7);
			end
			if (in_valid && !in_ready) begin
				in_valid <= 1'b1;
			end else if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				mask_cmd_t c;
				c = pending_cmds.pop_front();
				in_valid <= 1'b1;
				op <= c.op;
				pixel_index <= c.idx;
				pixel_in <= c.pix;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor: compares each result transaction with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				bmr_pkg::res_t e;
				if (expected_results.size() == 0) begin
					$display("%0t unexpected result transaction", $time);
					errors++;
				end else begin
					e = expected_results.pop_front();
					check_field("status", e.status, status);
					check_field("pixel_out", e.pix, pixel_out);
					check_field("fg_before", e.fg_before, fg_before);
					check_field("fg_after", e.fg_after, fg_after);
					check_field("comps_before", e.comps_before, comps_before);
					check_field("comps_after", e.comps_after, comps_after);
					check_field("comps_removed", e.comps_removed, comps_removed);
					check_field("holes_filled", e.holes_filled, holes_filled);
					check_field("passes_done", e.passes_done, passes_done);
				end
				out_stall = calm ? 0 : $urandom_range(0, 7);
			end
			if (out_stall > 0) begin
				out_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic queue_cmd(bmr_pkg::op_t o, int idx, bit pix);
		mask_cmd_t c;
		c.op = o;
		c.idx = idx[bmr_pkg::AW-1:0];
		c.pix = pix;
		pending_cmds.insert(pending_cmds.size(), c);
		gen_count++;
	endtask

	// Waits until the block is drained; sampled at the falling edge so every update has settled.
	task automatic wait_idle();
		while (pending_cmds.size() != 0 || expected_results.size() != 0 || in_valid)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [bmr_pkg::CFG_AW-1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[bmr_pkg::CNT_W-1:0];
		case (idx)
			bmr_pkg::CFG_WIDTH:     cw = val & 'h1FF;
			bmr_pkg::CFG_HEIGHT:    ch = val & 'h1FF;
			bmr_pkg::CFG_LARGEST:   ckeep = val & 1;
			bmr_pkg::CFG_MIN_SIZE:  cmin = val & 'h1FFFF;
			bmr_pkg::CFG_FILL_EN:   cfill = val & 1;
			bmr_pkg::CFG_SMOOTH_EN: csmooth = val & 1;
			bmr_pkg::CFG_PASSES:    cpass = val & 'hF;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(int w, int h, int keep, int mins, int fill, int sm, int passes);
		wait_idle();
		write_reg(bmr_pkg::CFG_WIDTH, w);
		write_reg(bmr_pkg::CFG_HEIGHT, h);
		write_reg(bmr_pkg::CFG_LARGEST, keep);
		write_reg(bmr_pkg::CFG_MIN_SIZE, mins);
		write_reg(bmr_pkg::CFG_FILL_EN, fill);
		write_reg(bmr_pkg::CFG_SMOOTH_EN, sm);
		write_reg(bmr_pkg::CFG_PASSES, passes);
	endtask

	// Loads the whole mask so that no run or read touches an unwritten pixel.
	task automatic load_mask(int density);
		int n, w, h, x0, y0, x1, y1;
		w = eff_w();
		h = eff_h();
		n = w * h;
		for (int i = 0; i < n; i++) queue_cmd(bmr_pkg::OP_WRITE, i, ($urandom % 100) < density);
		// A rectangle outline often encloses a hole.
		if (w >= 3 && h >= 3 && $urandom_range(0, 1)) begin
			x0 = $urandom_range(0, w - 3);
			y0 = $urandom_range(0, h - 3);
			x1 = $urandom_range(x0 + 2, w - 1);
			y1 = $urandom_range(y0 + 2, h - 1);
			for (int y = y0; y <= y1; y++)
				for (int x = x0; x <= x1; x++)
					queue_cmd(bmr_pkg::OP_WRITE, y * w + x,
						(x == x0 || x == x1 || y == y0 || y == y1) ? 1'b1 : 1'b0);
		end
	endtask

	initial begin
		int w, h, n, ops, sel, mins, passes, idx;
		cw = 256; ch = 256; ckeep = 1; cmin = 0; cfill = 1; csmooth = 0; cpass = 1;
		for (int i = 0; i < 7; i++) rc[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: a 4x4 mask with a hole, edge indexes and every operation.
		configure(4, 4, 1, 0, 1, 1, 15);
		calm = 1'b1;
		for (int i = 0; i < 16; i++)
			queue_cmd(bmr_pkg::OP_WRITE, i, (i == 5 || i == 15) ? 1'b0 :
				((i % 4 == 0 || i < 4 || i > 11 || i % 4 == 3) ? 1'b1 : 1'b0));
		queue_cmd(bmr_pkg::OP_READ, 15, 1'b0);
		queue_cmd(bmr_pkg::OP_WRITE, 16, 1'b1);
		queue_cmd(bmr_pkg::OP_READ, 65535, 1'b0);
		queue_cmd(bmr_pkg::OP_NONE, 65535, 1'b1);
		queue_cmd(bmr_pkg::OP_RUN, 0, 1'b0);
		queue_cmd(bmr_pkg::OP_READ, 5, 1'b0);
		queue_cmd(bmr_pkg::OP_READ, 0, 1'b0);

		// Directed: an empty mask with the size rule at its largest setting.
		configure(3, 3, 0, 131071, 0, 1, 0);
		for (int i = 0; i < 9; i++) queue_cmd(bmr_pkg::OP_WRITE, i, 1'b0);
		queue_cmd(bmr_pkg::OP_RUN, 0, 1'b0);

		// Random phases, each with its own configuration and a full mask load.
		while (gen_count < ITEM_TARGET) begin
			sel = $urandom_range(0, 9);
			if (sel == 0) begin w = 256; h = 1; end
			else if (sel == 1) begin w = 1; h = 511; end
			else if (sel == 2) begin w = 0; h = $urandom_range(1, 12); end
			else if (sel == 3) begin w = $urandom_range(1, 2); h = $urandom_range(1, 16); end
			else begin w = $urandom_range(3, 14); h = $urandom_range(3, 14); end
			sel = $urandom_range(0, 9);
			mins = (sel == 0) ? 65536 : ((sel == 1) ? 131071 : $urandom_range(0, 10));
			sel = $urandom_range(0, 9);
			passes = (sel == 0) ? 15 : ((sel == 1) ? 0 : $urandom_range(1, 3));
			configure(w, h, $urandom_range(0, 1), mins, $urandom_range(0, 1),
				$urandom_range(0, 1), passes);
			calm = ($urandom_range(0, 3) == 0);
			n = eff_w() * eff_h();
			load_mask($urandom_range(20, 80));
			ops = $urandom_range(20, 60);
			for (int k = 0; k < ops; k++) begin
				sel = $urandom_range(0, 99);
				if (sel < 6) idx = $urandom_range(0, 65535);
				else idx = $urandom_range(0, n - 1);
				if (sel < 45) queue_cmd(bmr_pkg::OP_WRITE, idx, $urandom_range(0, 1));
				else if (sel < 84) queue_cmd(bmr_pkg::OP_READ, idx, $urandom_range(0, 1));
				else if (sel < 96)
					queue_cmd(bmr_pkg::OP_RUN, $urandom_range(0, 65535), $urandom_range(0, 1));
				else
					queue_cmd(bmr_pkg::OP_NONE, $urandom_range(0, 65535), $urandom_range(0, 1));
			end
			queue_cmd(bmr_pkg::OP_RUN, 0, 1'b0);
			for (int k = 0; k < 6; k++)
				queue_cmd(bmr_pkg::OP_READ, $urandom_range(0, n - 1), 1'b0);
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/bmr_pkg.sv
rtl/bmr_ram.sv
rtl/bmr_seq.sv
rtl/binary_mask_refiner.sv
verif/tb_binary_mask_refiner.sv
